// File: rtl/nocs_pkg.sv
// ----------------------------------------------------------------------------
// nocs_pkg: shared types and constants
// Codes, widths and the ring walker record for the nearest occupied cell search.
// ----------------------------------------------------------------------------
`default_nettype none

package nocs_pkg;

   // coordinate width inside the store and the scan (covers 0..511)
   localparam int unsigned COORD_W    = 9;
   // signed ring offset width (covers -256..255)
   localparam int unsigned OFS_W      = 9;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 9;

   // command codes of a request transaction
   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_LIM  = 2'd2;

   // control states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // current candidate offset from the ring walker
   typedef struct packed {
      logic signed [OFS_W-1:0] dx;
      logic signed [OFS_W-1:0] dy;
      logic                    last;
   } walk_type;

endpackage

`default_nettype wire

// File: rtl/nocs_if.sv
// ----------------------------------------------------------------------------
// nocs_if: channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface nocs_req_if;
   logic              valid;
   logic              ready;
   logic              command;
   logic [7:0]        cell_x;
   logic [7:0]        cell_y;
   logic signed [7:0] cell_value;

   modport source (output valid, command, cell_x, cell_y, cell_value, input ready);
   modport sink   (input valid, command, cell_x, cell_y, cell_value, output ready);
endinterface

interface nocs_rsp_if;
   logic       valid;
   logic       ready;
   logic       found;
   logic [7:0] near_x;
   logic [7:0] near_y;

   modport source (output valid, found, near_x, near_y, input ready);
   modport sink   (input valid, found, near_x, near_y, output ready);
endinterface

interface nocs_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [nocs_pkg::CSR_IDX_W-1:0]       index;
   logic [nocs_pkg::CSR_DATA_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/nearest_occupied_cell_search.sv
// ----------------------------------------------------------------------------
// nearest_occupied_cell_search: occupancy grid with ring search
// Write transaction: no response. Query: one grid cell read per cycle
// from the single store read port; the scan ends at the first hit or after the
// last candidate for radius limit R, then loads the response once the slot is free.
// Next request accepted once the block is back in idle (the cycle after load).
// Synchronous reset clears control and loads config defaults; grid contents are undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_occupied_cell_search #(
   parameter int unsigned GRID_SIDE = 256
) (
   input  wire logic   clock,
   input  wire logic   reset,
   nocs_req_if.sink    req_chan,
   nocs_rsp_if.source  rsp_chan,
   nocs_csr_if.sink    csr_chan
);

   localparam int unsigned SIDE_CAP = (GRID_SIDE > 511) ? 511 : GRID_SIDE;
   localparam logic [8:0]  SIDE_LIM = 9'(SIDE_CAP);

   nocs_pkg::state_type state_ff, state_in;

   logic [8:0]  grid_width_ff;
   logic [8:0]  grid_height_ff;
   logic [7:0]  radius_lim_ff;
   logic [8:0]  lim_x;
   logic [8:0]  lim_y;

   logic [7:0]  src_x_ff;
   logic [7:0]  src_y_ff;
   logic        iss_ff;
   logic        p_act_ff;
   logic        p_in_ff;
   logic        p_last_ff;
   logic [7:0]  p_x_ff;
   logic [7:0]  p_y_ff;
   logic        res_found_ff;
   logic [7:0]  res_x_ff;
   logic [7:0]  res_y_ff;
   logic        rsp_valid_ff;
   logic        rsp_found_ff;
   logic [7:0]  rsp_x_ff;
   logic [7:0]  rsp_y_ff;

   logic        req_accept;
   logic        is_query;
   logic        start;
   logic        issue;
   logic        wr_en;
   logic        wr_in_store;
   logic        occupied;
   logic        rd_en;
   logic        rd_data;
   logic        hit;
   logic        miss;
   logic        rsp_load;
   logic        slot_free;

   logic signed [9:0]  nx;
   logic signed [9:0]  ny;
   logic               in_grid;
   nocs_pkg::walk_type walk;

   // configuration registers, always ready
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= 9'd256;
         grid_height_ff <= 9'd256;
         radius_lim_ff  <= 8'd60;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            nocs_pkg::CSR_GRID_WIDTH:  grid_width_ff  <= csr_chan.data;
            nocs_pkg::CSR_GRID_HEIGHT: grid_height_ff <= csr_chan.data;
            nocs_pkg::CSR_RADIUS_LIM:  radius_lim_ff  <= csr_chan.data[7:0];
            default: ;
         endcase
      end
   end

   // clamp the active grid to the store side
   assign lim_x = (grid_width_ff  > SIDE_LIM) ? SIDE_LIM : grid_width_ff;
   assign lim_y = (grid_height_ff > SIDE_LIM) ? SIDE_LIM : grid_height_ff;

   // request decode
   assign req_accept  = req_chan.valid && req_chan.ready;
   assign is_query    = (req_chan.command == nocs_pkg::CMD_QUERY);
   assign wr_in_store = ({1'b0, req_chan.cell_x} < SIDE_LIM) &&
                        ({1'b0, req_chan.cell_y} < SIDE_LIM);
   assign occupied    = !req_chan.cell_value[7] && (req_chan.cell_value != 8'sd0);

   // candidate cell and bounds check
   assign nx = $signed({2'b00, src_x_ff}) + $signed({walk.dx[8], walk.dx});
   assign ny = $signed({2'b00, src_y_ff}) + $signed({walk.dy[8], walk.dy});
   assign in_grid = !nx[9] && !ny[9] && (nx[8:0] < lim_x) && (ny[8:0] < lim_y);

   // read data of the previous candidate decides the scan
   assign hit       = p_act_ff && p_in_ff && rd_data;
   assign miss      = p_act_ff && p_last_ff && !hit;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nocs_pkg::ST_IDLE: begin
            if (req_accept && is_query) state_in = nocs_pkg::ST_SCAN;
         end
         nocs_pkg::ST_SCAN: begin
            if (hit || miss) state_in = nocs_pkg::ST_DONE;
         end
         nocs_pkg::ST_DONE: begin
            if (slot_free) state_in = nocs_pkg::ST_IDLE;
         end
         default: state_in = nocs_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_chan.ready = 1'b0;
      start          = 1'b0;
      wr_en          = 1'b0;
      issue          = 1'b0;
      rsp_load       = 1'b0;
      unique case (state_ff)
         nocs_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            start          = req_accept && is_query;
            wr_en          = req_accept && !is_query && wr_in_store;
         end
         nocs_pkg::ST_SCAN: begin
            issue = iss_ff && !hit;
         end
         nocs_pkg::ST_DONE: begin
            rsp_load = slot_free;
         end
         default: ;
      endcase
   end

   assign rd_en = issue && in_grid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nocs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // latch the query source
   always_ff @(posedge clock) begin
      if (start) begin
         src_x_ff <= req_chan.cell_x;
         src_y_ff <= req_chan.cell_y;
      end
   end

   // issue flag: high while candidates remain and none has hit
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff <= 1'b0;
      end else if (start) begin
         iss_ff <= 1'b1;
      end else if (hit || (issue && walk.last)) begin
         iss_ff <= 1'b0;
      end
   end

   // track the candidate whose read is in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         p_act_ff <= 1'b0;
      end else begin
         p_act_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      p_in_ff   <= in_grid;
      p_last_ff <= walk.last;
      p_x_ff    <= nx[7:0];
      p_y_ff    <= ny[7:0];
   end

   // hold the scan outcome
   always_ff @(posedge clock) begin
      if ((state_ff == nocs_pkg::ST_SCAN) && (hit || miss)) begin
         res_found_ff <= hit;
         res_x_ff     <= hit ? p_x_ff : 8'd0;
         res_y_ff     <= hit ? p_y_ff : 8'd0;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_found_ff <= res_found_ff;
         rsp_x_ff     <= res_x_ff;
         rsp_y_ff     <= res_y_ff;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.found  = rsp_found_ff;
   assign rsp_chan.near_x = rsp_x_ff;
   assign rsp_chan.near_y = rsp_y_ff;

   nocs_ring_walker u_walker (
      .clock      (clock),
      .start      (start),
      .step       (issue && !walk.last),
      .radius_lim (radius_lim_ff),
      .walk       (walk)
   );

   nocs_grid_store #(
      .GRID_SIDE (GRID_SIDE)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_x    ({1'b0, req_chan.cell_x}),
      .wr_y    ({1'b0, req_chan.cell_y}),
      .wr_data (occupied),
      .rd_en   (rd_en),
      .rd_x    (nx[8:0]),
      .rd_y    (ny[8:0]),
      .rd_data (rd_data)
   );

   // a scan always has a candidate pending or in flight
   a_scan_alive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nocs_pkg::ST_SCAN) |-> (iss_ff || p_act_ff))
      else $error("scan stalled with nothing in flight");

   // nothing is issued after the final candidate
   a_last_once: assert property (@(posedge clock) disable iff (reset)
      (p_act_ff && p_last_ff) |-> !iss_ff)
      else $error("candidate issued after the final one");

   // an accepted query starts a scan
   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      start |=> ((state_ff == nocs_pkg::ST_SCAN) && iss_ff))
      else $error("query did not start a scan");

endmodule

`default_nettype wire

// File: rtl/nocs_grid_store.sv
// ----------------------------------------------------------------------------
// nocs_grid_store: occupancy bit memory
// One bit per cell, one write port and one registered read port, row-major.
// ----------------------------------------------------------------------------
`default_nettype none

module nocs_grid_store #(
   parameter int unsigned GRID_SIDE = 256
) (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [nocs_pkg::COORD_W-1:0] wr_x,
   input  wire logic [nocs_pkg::COORD_W-1:0] wr_y,
   input  wire logic                         wr_data,
   input  wire logic                         rd_en,
   input  wire logic [nocs_pkg::COORD_W-1:0] rd_x,
   input  wire logic [nocs_pkg::COORD_W-1:0] rd_y,
   output      logic                         rd_data
);

   localparam int unsigned DEPTH  = GRID_SIDE * GRID_SIDE;
   localparam int unsigned ADDR_W = $clog2(DEPTH);

   logic              mem [DEPTH];
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic              rd_data_ff;

   // map row and column to a linear address
   assign wr_addr = ADDR_W'(wr_y) * ADDR_W'(GRID_SIDE) + ADDR_W'(wr_x);
   assign rd_addr = ADDR_W'(rd_y) * ADDR_W'(GRID_SIDE) + ADDR_W'(rd_x);

   // write one cell
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read one cell, data valid next cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/nocs_ring_walker.sv
// ----------------------------------------------------------------------------
// nocs_ring_walker: ring scan sequencer
// Steps through square rings of growing radius, dx outer and dy inner,
// visiting only cells on the ring border. Radius zero is the source itself.
// ----------------------------------------------------------------------------
`default_nettype none

module nocs_ring_walker (
   input  wire logic               clock,
   input  wire logic               start,
   input  wire logic               step,
   input  wire logic [7:0]         radius_lim,
   output      nocs_pkg::walk_type walk
);

   logic [7:0]                        r_ff, r_in;
   logic signed [nocs_pkg::OFS_W-1:0] dx_ff, dx_in;
   logic signed [nocs_pkg::OFS_W-1:0] dy_ff, dy_in;
   logic signed [nocs_pkg::OFS_W-1:0] rs;
   logic signed [nocs_pkg::OFS_W-1:0] neg_r;
   logic signed [nocs_pkg::OFS_W-1:0] r_next;
   logic                              on_edge;

   assign rs      = $signed({1'b0, r_ff});
   assign neg_r   = -rs;
   assign r_next  = rs + 9'sd1;
   assign on_edge = (dx_ff == rs) || (dx_ff == neg_r);

   // advance to the next border cell
   always_comb begin
      r_in  = r_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      priority if (start) begin
         r_in  = 8'd0;
         dx_in = '0;
         dy_in = '0;
      end else if (step) begin
         priority if (dy_ff != rs) begin
            // full column on an edge, otherwise jump from top to bottom
            dy_in = on_edge ? dy_ff + 9'sd1 : rs;
         end else if (dx_ff != rs) begin
            dx_in = dx_ff + 9'sd1;
            dy_in = neg_r;
         end else begin
            r_in  = r_ff + 8'd1;
            dx_in = -r_next;
            dy_in = -r_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      r_ff  <= r_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
   end

   assign walk.dx   = dx_ff;
   assign walk.dy   = dy_ff;
   assign walk.last = (dy_ff == rs) && (dx_ff == rs) && (r_ff == radius_lim);

endmodule

`default_nettype wire
